// ----- design/seq_stream_to_midi_converter_assert.svh -----
// assertion macros for the sequence to midi converter
`ifndef SEQ_STREAM_TO_MIDI_CONVERTER_ASSERT_SVH
`define SEQ_STREAM_TO_MIDI_CONVERTER_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define S2M_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication held from one cycle to the next
`define S2M_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/s2m_pkg.sv -----
// shared types and constants for the sequence to midi converter
package s2m_pkg;

    localparam logic [2:0] ST_BYTE      = 3'd0;
    localparam logic [2:0] ST_FINISHED  = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_NO_RUN    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    localparam int PROLOGUE_LEN = 37;
    localparam int FILE_HDR_LEN = 22;

    // work orders from the front part to the emitter
    localparam logic [1:0] JOB_BYTES    = 2'd0;
    localparam logic [1:0] JOB_PROLOGUE = 2'd1;
    localparam logic [1:0] JOB_END_META = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  delta_groups;
        logic [27:0] delta;
        logic        run_out;
        logic [7:0]  run_byte;
        logic        out_a;
        logic [7:0]  byte_a;
        logic        out_b;
        logic [7:0]  byte_b;
        logic [2:0]  fin_status;
    } job_t;

    typedef struct packed {
        logic [15:0] tpq;
        logic [23:0] tempo;
        logic [7:0]  num;
        logic [7:0]  den;
    } hdr_t;

    function automatic logic [7:0] prologue_byte(input logic [5:0] idx, input hdr_t h);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            6'd0:  b = 8'h4D;
            6'd1:  b = 8'h54;
            6'd2:  b = 8'h68;
            6'd3:  b = 8'h64;
            6'd7:  b = 8'h06;
            6'd11: b = 8'h01;
            6'd12: b = h.tpq[15:8];
            6'd13: b = h.tpq[7:0];
            6'd14: b = 8'h4D;
            6'd15: b = 8'h54;
            6'd16: b = 8'h72;
            6'd17: b = 8'h6B;
            6'd23: b = 8'hFF;
            6'd24: b = 8'h51;
            6'd25: b = 8'h03;
            6'd26: b = h.tempo[23:16];
            6'd27: b = h.tempo[15:8];
            6'd28: b = h.tempo[7:0];
            6'd30: b = 8'hFF;
            6'd31: b = 8'h58;
            6'd32: b = 8'h04;
            6'd33: b = h.num;
            6'd34: b = h.den;
            6'd35: b = 8'h18;
            6'd36: b = 8'h08;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/s2m_parser.sv -----
// front part: parses the sequence stream and issues emit jobs
module s2m_parser #(
    parameter int MAX_VLQ_BYTES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [7:0]        in_byte,
    output logic              job_valid,
    input  logic              job_ready,
    output s2m_pkg::job_t     job,
    output s2m_pkg::hdr_t     hdr
);
    import s2m_pkg::*;

    localparam logic [3:0] PH_SIG       = 4'd0;
    localparam logic [3:0] PH_HDR       = 4'd1;
    localparam logic [3:0] PH_DELTA     = 4'd2;
    localparam logic [3:0] PH_STATUS    = 4'd3;
    localparam logic [3:0] PH_FIRST     = 4'd4;
    localparam logic [3:0] PH_DATA      = 4'd5;
    localparam logic [3:0] PH_META_LEN  = 4'd6;
    localparam logic [3:0] PH_META_DATA = 4'd7;
    localparam logic [3:0] PH_DONE      = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  hidx_reg, hidx_next;
    hdr_t        hdr_reg, hdr_next;
    logic [7:0]  run_reg, run_next;
    logic [27:0] delta_reg, delta_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [27:0] rem_reg, rem_next;
    logic [7:0]  meta_reg, meta_next;
    logic        halted_reg, halted_next;
    job_t        j;
    logic        fire, has_job;
    logic [7:0]  sig;
    logic [27:0] rem_acc;
    logic        vlq_end;

    assign in_ready = job_ready || halted_reg;
    assign fire = in_valid && in_ready;
    assign job_valid = in_valid && !halted_reg && has_job;
    assign job = j;
    assign hdr = hdr_reg;

    always_comb
    begin
        case (hidx_reg[1:0])
            2'd0: sig = 8'h71;
            2'd1: sig = 8'h51;
            2'd2: sig = 8'h45;
            default: sig = 8'h53;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        hidx_next = hidx_reg;
        hdr_next = hdr_reg;
        run_next = run_reg;
        delta_next = delta_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        meta_next = meta_reg;
        halted_next = halted_reg;
        j = '0;
        j.kind = JOB_BYTES;
        has_job = 1'b0;
        rem_acc = {rem_reg[20:0], in_byte[6:0]};
        vlq_end = (32'(cnt_reg) + 32'd1 >= 32'(MAX_VLQ_BYTES)) || !in_byte[7];
        if (cmd) begin
            has_job = 1'b1;
            j.fin_status = (phase_reg == PH_SIG) ? ST_BAD_SIG : ST_TRUNCATED;
            halted_next = 1'b1;
            phase_next = PH_DONE;
        end else begin
            unique case (phase_reg)
                PH_SIG:
                begin
                    if (in_byte != sig) begin
                        has_job = 1'b1;
                        j.fin_status = ST_BAD_SIG;
                        halted_next = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        hidx_next = hidx_reg + 4'd1;
                        if (hidx_reg == 4'd3)
                            phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    case (hidx_reg)
                        4'd8:  hdr_next.tpq[15:8] = in_byte;
                        4'd9:  hdr_next.tpq[7:0] = in_byte;
                        4'd10: hdr_next.tempo[23:16] = in_byte;
                        4'd11: hdr_next.tempo[15:8] = in_byte;
                        4'd12: hdr_next.tempo[7:0] = in_byte;
                        4'd13: hdr_next.num = in_byte;
                        4'd14: hdr_next.den = in_byte;
                        default: ;
                    endcase
                    if (hidx_reg == 4'd15) begin
                        has_job = 1'b1;
                        j.kind = JOB_PROLOGUE;
                        phase_next = PH_DELTA;
                        delta_next = '0;
                        cnt_next = '0;
                    end else begin
                        hidx_next = hidx_reg + 4'd1;
                    end
                end
                PH_DELTA:
                begin
                    delta_next = {delta_reg[20:0], in_byte[6:0]};
                    cnt_next = cnt_reg + 3'd1;
                    if (vlq_end)
                        phase_next = PH_STATUS;
                end
                PH_STATUS:
                begin
                    has_job = 1'b1;
                    if (delta_reg == 28'h3FAF && in_byte == 8'h00) begin
                        j.kind = JOB_END_META;
                        j.fin_status = ST_FINISHED;
                        halted_next = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        j.delta_groups = cnt_reg;
                        j.delta = delta_reg;
                        if (in_byte[7]) begin
                            run_next = in_byte;
                            j.out_a = 1'b1;
                            j.byte_a = in_byte;
                            phase_next = PH_FIRST;
                        end else if (!run_reg[7]) begin
                            j.fin_status = ST_NO_RUN;
                            halted_next = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            if (run_reg[7:4] == 4'hF) begin
                                j.run_out = 1'b1;
                                j.run_byte = run_reg;
                            end
                            if (run_reg[7:4] == 4'hF && run_reg != 8'hFF) begin
                                j.fin_status = ST_UNKNOWN;
                                halted_next = 1'b1;
                                phase_next = PH_DONE;
                            end else begin
                                j.out_a = 1'b1;
                                j.byte_a = in_byte;
                                if (run_reg == 8'hFF) begin
                                    meta_next = in_byte;
                                    rem_next = '0;
                                    cnt_next = '0;
                                    phase_next = PH_META_LEN;
                                end else if (run_reg[7:4] == 4'hC || run_reg[7:4] == 4'hD) begin
                                    phase_next = PH_DELTA;
                                    delta_next = '0;
                                    cnt_next = '0;
                                end else begin
                                    rem_next = 28'd1;
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                    end
                end
                PH_FIRST:
                begin
                    has_job = 1'b1;
                    if (run_reg[7:4] == 4'hF && run_reg != 8'hFF) begin
                        j.fin_status = ST_UNKNOWN;
                        halted_next = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        j.out_a = 1'b1;
                        j.byte_a = in_byte;
                        if (run_reg == 8'hFF) begin
                            meta_next = in_byte;
                            rem_next = '0;
                            cnt_next = '0;
                            phase_next = PH_META_LEN;
                        end else if (run_reg[7:4] == 4'hC || run_reg[7:4] == 4'hD) begin
                            phase_next = PH_DELTA;
                            delta_next = '0;
                            cnt_next = '0;
                        end else begin
                            rem_next = 28'd1;
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    has_job = 1'b1;
                    j.out_a = 1'b1;
                    j.byte_a = in_byte;
                    phase_next = PH_DELTA;
                    delta_next = '0;
                    cnt_next = '0;
                end
                PH_META_LEN:
                begin
                    has_job = 1'b1;
                    j.out_a = 1'b1;
                    j.byte_a = in_byte;
                    rem_next = rem_acc;
                    cnt_next = cnt_reg + 3'd1;
                    if (vlq_end) begin
                        if (rem_acc != '0) begin
                            phase_next = PH_META_DATA;
                        end else if (meta_reg == 8'h2F) begin
                            j.fin_status = ST_FINISHED;
                            halted_next = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_DELTA;
                            delta_next = '0;
                            cnt_next = '0;
                        end
                    end
                end
                PH_META_DATA:
                begin
                    has_job = 1'b1;
                    j.out_a = 1'b1;
                    j.byte_a = in_byte;
                    rem_next = rem_reg - 28'd1;
                    if (rem_reg == 28'd1) begin
                        if (meta_reg == 8'h2F) begin
                            j.fin_status = ST_FINISHED;
                            halted_next = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            phase_next = PH_DELTA;
                            delta_next = '0;
                            cnt_next = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_SIG;
            hidx_reg <= '0;
            hdr_reg <= '0;
            run_reg <= '0;
            delta_reg <= '0;
            cnt_reg <= '0;
            rem_reg <= '0;
            meta_reg <= '0;
            halted_reg <= 1'b0;
        end else if (fire && !halted_reg) begin
            phase_reg <= phase_next;
            hidx_reg <= hidx_next;
            hdr_reg <= hdr_next;
            run_reg <= run_next;
            delta_reg <= delta_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            meta_reg <= meta_next;
            halted_reg <= halted_next;
        end
    end

    `include "seq_stream_to_midi_converter_assert.svh"
    `S2M_ASSERT(a_hidx_range, hidx_reg <= 4'd15, "header index out of range")
    `S2M_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halt released")
    `S2M_ASSERT(a_halt_done, halted_reg == (phase_reg == PH_DONE), "halt and phase disagree")
endmodule

// ----- design/s2m_job_fifo.sv -----
// short queue of emit jobs between parser and emitter
module s2m_job_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  s2m_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output s2m_pkg::job_t rd_job
);
    import s2m_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr_fire, rd_fire;

    assign wr_ready = cnt_reg != (AW + 1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_job = mem[rp_reg];
    assign wr_fire = wr_valid && wr_ready;
    assign rd_fire = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_fire)
            mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_fire)
                wp_reg <= (32'(wp_reg) == DEPTH - 1) ? '0 : wp_reg + 1'b1;
            if (rd_fire)
                rp_reg <= (32'(rp_reg) == DEPTH - 1) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW + 1)'(wr_fire) - (AW + 1)'(rd_fire);
        end
    end
endmodule

// ----- design/s2m_emitter.sv -----
// back part: expands jobs into output bytes and counts the track length
module s2m_emitter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  s2m_pkg::job_t job,
    input  s2m_pkg::hdr_t hdr,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [2:0]    status,
    output logic [31:0]   track_length,
    output logic          last
);
    import s2m_pkg::*;

    // step codes within one job
    localparam logic [2:0] SP_PRO   = 3'd0;
    localparam logic [2:0] SP_DELTA = 3'd1;
    localparam logic [2:0] SP_RUN   = 3'd2;
    localparam logic [2:0] SP_A     = 3'd3;
    localparam logic [2:0] SP_END   = 3'd4;
    localparam logic [2:0] SP_FIN   = 3'd5;
    localparam logic [2:0] SP_DONE  = 3'd6;

    logic [2:0]  step_reg, step_next;
    logic [5:0]  idx_reg, idx_next;
    logic [31:0] count_reg, count_next;
    logic        busy_reg;
    logic [7:0]  ob_reg;
    logic [2:0]  st_reg;
    logic [31:0] tl_reg;
    logic        last_reg, ov_reg;
    logic        can_load;
    logic        emit_now;
    logic [7:0]  e_byte;
    logic [2:0]  e_st;
    logic [31:0] e_tl;
    logic        e_last;
    logic [4:0]  sh;
    logic [27:0] shifted;
    logic [2:0]  first_step;

    function automatic logic [2:0] after(input logic [2:0] s, input job_t jb);
        logic [2:0] n;
        n = SP_DONE;
        if (s < SP_RUN && jb.run_out) n = SP_RUN;
        else if (s < SP_A && jb.out_a) n = SP_A;
        else if (jb.fin_status != ST_BYTE) n = SP_FIN;
        return n;
    endfunction

    assign can_load = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_byte = ob_reg;
    assign status = st_reg;
    assign track_length = tl_reg;
    assign last = last_reg;

    always_comb
    begin
        unique case (job.kind)
            JOB_PROLOGUE: first_step = SP_PRO;
            JOB_END_META: first_step = SP_END;
            default:
            begin
                if (job.delta_groups != '0) first_step = SP_DELTA;
                else first_step = after(SP_PRO, job);
            end
        endcase
    end

    always_comb
    begin
        sh = 5'(idx_reg[2:0]) * 5'd7;
        shifted = job.delta >> sh;
        step_next = step_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        emit_now = 1'b0;
        e_byte = 8'h00;
        e_st = ST_BYTE;
        e_tl = '0;
        e_last = 1'b0;
        if (busy_reg) begin
            emit_now = 1'b1;
            unique case (step_reg)
                SP_PRO:
                begin
                    e_byte = prologue_byte(idx_reg, hdr);
                    if (idx_reg == 6'(PROLOGUE_LEN - 1)) begin
                        count_next = 32'(PROLOGUE_LEN - FILE_HDR_LEN);
                        step_next = SP_DONE;
                        e_last = 1'b1;
                    end else begin
                        count_next = count_reg + 32'd1;
                        idx_next = idx_reg + 6'd1;
                    end
                end
                SP_DELTA:
                begin
                    // groups from the extra leading one down to zero
                    e_byte = {(idx_reg != '0), shifted[6:0]};
                    count_next = count_reg + 32'd1;
                    if (idx_reg == '0) begin
                        step_next = after(SP_DELTA, job);
                        e_last = after(SP_DELTA, job) == SP_DONE;
                    end else begin
                        idx_next = idx_reg - 6'd1;
                    end
                end
                SP_RUN:
                begin
                    e_byte = job.run_byte;
                    count_next = count_reg + 32'd1;
                    step_next = after(SP_RUN, job);
                    e_last = after(SP_RUN, job) == SP_DONE;
                end
                SP_A:
                begin
                    e_byte = job.byte_a;
                    count_next = count_reg + 32'd1;
                    step_next = after(SP_A, job);
                    e_last = after(SP_A, job) == SP_DONE;
                end
                SP_END:
                begin
                    case (idx_reg[1:0])
                        2'd1: e_byte = 8'hFF;
                        2'd2: e_byte = 8'h2F;
                        default: e_byte = 8'h00;
                    endcase
                    count_next = count_reg + 32'd1;
                    if (idx_reg[1:0] == 2'd3) step_next = SP_FIN;
                    else idx_next = idx_reg + 6'd1;
                end
                SP_FIN:
                begin
                    e_st = job.fin_status;
                    e_tl = (job.fin_status == ST_FINISHED) ? count_reg : '0;
                    e_last = 1'b1;
                    step_next = SP_DONE;
                end
                default: emit_now = 1'b0;
            endcase
        end
    end

    assign job_ready = busy_reg && can_load && (step_next == SP_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= SP_DONE;
            idx_reg <= '0;
            count_reg <= '0;
            ov_reg <= 1'b0;
            ob_reg <= '0;
            tl_reg <= '0;
            last_reg <= 1'b0;
            st_reg <= ST_BYTE;
        end else if (can_load) begin
            ov_reg <= emit_now;
            if (emit_now) begin
                ob_reg <= e_byte;
                st_reg <= e_st;
                tl_reg <= e_tl;
                last_reg <= e_last;
            end
            count_reg <= count_next;
            if (!busy_reg || step_next == SP_DONE) begin
                // pick up the next job at a free slot
                busy_reg <= job_valid && !(busy_reg);
                if (job_valid && !busy_reg) begin
                    step_reg <= first_step;
                    idx_reg <= (job.kind == JOB_BYTES) ? 6'(job.delta_groups) : '0;
                end else begin
                    step_reg <= SP_DONE;
                end
            end else begin
                step_reg <= step_next;
                idx_reg <= (step_next != step_reg) ? '0 : idx_next;
                if (step_reg == SP_DELTA && step_next == SP_DELTA)
                    idx_reg <= idx_next;
            end
        end
    end

    `include "seq_stream_to_midi_converter_assert.svh"
    `S2M_ASSERT(a_out_status, !ov_reg || st_reg <= ST_TRUNCATED, "bad status code")
    `S2M_ASSERT(a_tl_zero, !ov_reg || st_reg == ST_FINISHED || tl_reg == '0,
        "track length on non finish result")
    `S2M_ASSERT(a_busy_step, !busy_reg || step_reg != SP_DONE, "busy without a step")
endmodule

// ----- design/seq_stream_to_midi_converter.sv -----
// top level of the sequence to midi converter
// Converts a sequence file, one byte per input transfer (cmd 1 ends the stream), into
// the bytes of a format-0 MIDI file, one byte or status per output transfer, last
// marking the final result of each input. A parser takes one input per cycle while the
// job queue has room and queues an emit job; the emitter gives no result while picking up
// a job and then one result per cycle while the output is accepted (inputs with no result
// cost no emitter time; the header's last byte gives 37, the byte after a delta up to 7).
// Track length is reported on finish.
module seq_stream_to_midi_converter #(
    parameter int MAX_VLQ_BYTES = 4,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic [31:0] track_length,
    output logic        last
);
    import s2m_pkg::*;

    job_t pj, qj;
    hdr_t hdr;
    logic pj_valid, pj_ready, qj_valid, qj_ready;

    s2m_parser #(.MAX_VLQ_BYTES(MAX_VLQ_BYTES)) u_parser (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .in_byte(in_byte), .job_valid(pj_valid), .job_ready(pj_ready),
        .job(pj), .hdr(hdr)
    );

    s2m_job_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_valid(pj_valid), .wr_ready(pj_ready),
        .wr_job(pj), .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
    );

    s2m_emitter u_emit (
        .clk(clk), .rst_n(rst_n), .job_valid(qj_valid), .job_ready(qj_ready),
        .job(qj), .hdr(hdr), .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .status(status), .track_length(track_length), .last(last)
    );
endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the sequence to midi converter
`timescale 1ns / 1ps

module tb_top;
    import s2m_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int QUIET_TAIL = 40;

    typedef enum logic [3:0] {
        PH_SIG, PH_HDR, PH_DELTA, PH_STATUS, PH_FIRST,
        PH_DATA, PH_META_LEN, PH_META_DATA, PH_DONE
    } conv_phase_e;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
    } seq_item_t;

    typedef struct {
        logic [7:0]  midi;
        logic [2:0]  st;
        logic [31:0] tlen;
        logic        fin;
    } midi_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [31:0] track_length;
    logic        last;

    seq_item_t seq_bytes[$];
    midi_res_t midi_expected[$];
    int        error_count = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    int        send_gap = 0;
    int        hold_cycles = 0;
    bit        pressure_done = 0;
    logic [7:0] gen_running = 8'h00;

    // converter state
    conv_phase_e ph;
    logic [3:0]  hdr_idx;
    logic [15:0] tpq;
    logic [23:0] tempo;
    logic [7:0]  ts_num;
    logic [7:0]  ts_den;
    logic [7:0]  run_op;
    logic [27:0] delta;
    logic [2:0]  vlq_cnt;
    logic [27:0] remaining;
    logic [7:0]  meta_kind;
    logic [31:0] emitted;
    logic        halted;

    seq_stream_to_midi_converter u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .in_byte(in_byte),
        .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
        .status(status), .track_length(track_length), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic push_res(input logic [7:0] b, input logic [2:0] st, input logic [31:0] tl);
        midi_res_t r;
        r.midi = b;
        r.st = st;
        r.tlen = tl;
        r.fin = 1'b0;
        midi_expected.push_back(r);
    endtask

    task automatic emit_midi(input logic [7:0] b);
        push_res(b, ST_BYTE, 32'd0);
        emitted++;
    endtask

    task automatic halt_with(input logic [2:0] st);
        push_res(8'h00, st, (st == ST_FINISHED) ? emitted : 32'd0);
        halted = 1'b1;
        ph = PH_DONE;
    endtask

    task automatic begin_event();
        ph = PH_DELTA;
        delta = '0;
        vlq_cnt = '0;
    endtask

    task automatic end_meta();
        if (meta_kind == 8'h2F)
            halt_with(ST_FINISHED);
        else
            begin_event();
    endtask

    task automatic take_first(input logic [7:0] b);
        if (run_op >= 8'hF0)
        begin
            if (run_op == 8'hFF)
            begin
                meta_kind = b;
                emit_midi(b);
                remaining = '0;
                vlq_cnt = '0;
                ph = PH_META_LEN;
            end
            else
                halt_with(ST_UNKNOWN);
        end
        else
        begin
            emit_midi(b);
            if (run_op[7:4] == 4'hC || run_op[7:4] == 4'hD)
                begin_event();
            else
            begin
                remaining = 28'd1;
                ph = PH_DATA;
            end
        end
    endtask

    task automatic emit_prologue();
        logic [7:0] p [0:36];
        p = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00,
              8'h00, 8'h01, tpq[15:8], tpq[7:0], 8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h51, 8'h03, tempo[23:16],
              tempo[15:8], tempo[7:0], 8'h00, 8'hFF, 8'h58, 8'h04, ts_num, ts_den,
              8'h18, 8'h08};
        for (int i = 0; i < PROLOGUE_LEN; i++)
            emit_midi(p[i]);
        emitted = 32'(PROLOGUE_LEN - FILE_HDR_LEN);
    endtask

    task automatic convert_byte(input logic c, input logic [7:0] b);
        int before_n;
        logic [7:0] sig [0:3];
        sig = '{8'h71, 8'h51, 8'h45, 8'h53};
        before_n = midi_expected.size();
        if (!halted)
        begin
            if (c)
                halt_with(ph == PH_SIG ? ST_BAD_SIG : ST_TRUNCATED);
            else
            begin
                case (ph)
                    PH_SIG:
                    begin
                        if (b != sig[hdr_idx[1:0]])
                            halt_with(ST_BAD_SIG);
                        else
                        begin
                            hdr_idx++;
                            if (hdr_idx >= 4) ph = PH_HDR;
                        end
                    end
                    PH_HDR:
                    begin
                        case (hdr_idx)
                            4'd8:  tpq[15:8] = b;
                            4'd9:  tpq[7:0] = b;
                            4'd10: tempo[23:16] = b;
                            4'd11: tempo[15:8] = b;
                            4'd12: tempo[7:0] = b;
                            4'd13: ts_num = b;
                            4'd14: ts_den = b;
                            default: ;
                        endcase
                        if (hdr_idx == 4'd15)
                        begin
                            emit_prologue();
                            begin_event();
                        end
                        else
                            hdr_idx++;
                    end
                    PH_DELTA:
                    begin
                        delta = {delta[20:0], b[6:0]};
                        vlq_cnt++;
                        if (vlq_cnt >= 4 || !b[7]) ph = PH_STATUS;
                    end
                    PH_STATUS:
                    begin
                        if (delta == 28'h3FAF && b == 8'h00)
                        begin
                            emit_midi(8'h00);
                            emit_midi(8'hFF);
                            emit_midi(8'h2F);
                            emit_midi(8'h00);
                            halt_with(ST_FINISHED);
                        end
                        else
                        begin
                            for (int i = int'(vlq_cnt); i >= 0; i--)
                                emit_midi({i != 0, 7'((delta >> (7 * i)) & 28'h7F)});
                            if (b[7])
                            begin
                                run_op = b;
                                emit_midi(b);
                                ph = PH_FIRST;
                            end
                            else if (run_op < 8'h80)
                                halt_with(ST_NO_RUN);
                            else
                            begin
                                if (run_op >= 8'hF0) emit_midi(run_op);
                                take_first(b);
                            end
                        end
                    end
                    PH_FIRST:
                        take_first(b);
                    PH_DATA:
                    begin
                        emit_midi(b);
                        if (remaining > 0) remaining--;
                        if (remaining == 0) begin_event();
                    end
                    PH_META_LEN:
                    begin
                        emit_midi(b);
                        remaining = {remaining[20:0], b[6:0]};
                        vlq_cnt++;
                        if (vlq_cnt >= 4 || !b[7])
                        begin
                            if (remaining > 0)
                                ph = PH_META_DATA;
                            else
                                end_meta();
                        end
                    end
                    PH_META_DATA:
                    begin
                        emit_midi(b);
                        if (remaining > 0) remaining--;
                        if (remaining == 0) end_meta();
                    end
                    default: ;
                endcase
            end
        end
        if (midi_expected.size() > before_n)
            midi_expected[midi_expected.size() - 1].fin = 1'b1;
    endtask

    // stimulus building
    task automatic add(input int c, input logic [7:0] b);
        seq_item_t it;
        it.cmd = (c != 0);
        it.data = b;
        seq_bytes.push_back(it);
    endtask

    task automatic add_header();
        add(0, 8'h71);
        add(0, 8'h51);
        add(0, 8'h45);
        add(0, 8'h53);
        for (int i = 4; i < 16; i++)
            add(0, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_delta();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        for (int i = 1; i < n; i++)
            add(0, 8'($urandom_range(0, 255)) | 8'h80);
        add(0, n == 4 ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127)));
    endtask

    task automatic add_meta_body(input int len);
        logic [7:0] kind;
        kind = 8'($urandom_range(0, 127));
        if (kind == 8'h2F) kind = 8'h01;
        add(0, kind);
        if (len >= 128)
        begin
            add(0, 8'h80 | 8'(len >> 7));
            add(0, 8'(len & 127));
        end
        else
            add(0, 8'(len));
        for (int i = 0; i < len; i++)
            add(0, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_channel_data(input logic [7:0] op, input logic [7:0] first);
        add(0, first);
        if (op[7:4] != 4'hC && op[7:4] != 4'hD)
            add(0, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_event();
        int pick;
        logic [7:0] op;
        add_delta();
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            if (gen_running == 8'hFF)
                add_meta_body($urandom_range(0, 5));
            else
                add_channel_data(gen_running, 8'($urandom_range(0, 127)));
        end
        else if (pick == 2)
        begin
            gen_running = 8'hFF;
            add(0, 8'hFF);
            add_meta_body($urandom_range(0, 5));
        end
        else
        begin
            op = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            gen_running = op;
            add(0, op);
            add_channel_data(op, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_stream();
        int kind;
        kind = $urandom_range(0, 11);
        if (kind == 12)
        begin
            for (int i = 0; i < 4; i++)
                if (i == 3)
                    add($urandom_range(0, 1), 8'h00);
                else
                    add(0, i == 0 ? 8'h71 : i == 1 ? 8'h51 : 8'h45);
        end
        else
        begin
            add_header();
            if (kind == 13)
            begin
                add(0, 8'h00);
                add(0, 8'($urandom_range(0, 127)));
            end
            else
            begin
                // hand-picked events: note on, program change, channel pressure, pitch bend, running status, metas
                add(0, 8'h00); add(0, 8'h90); add(0, 8'h00); add(0, 8'h7F);
                add(0, 8'h00); add(0, 8'h3C); add(0, 8'h40);
                add(0, 8'h7F); add(0, 8'hC5); add(0, 8'hFF);
                add(0, 8'h00); add(0, 8'hD0); add(0, 8'h00);
                add(0, 8'hFF); add(0, 8'hFF); add(0, 8'hFF); add(0, 8'hFF);
                add(0, 8'hE0); add(0, 8'hFF); add(0, 8'hFF);
                add(0, 8'h00); add(0, 8'hFF); add(0, 8'h06); add(0, 8'h00);
                add(0, 8'h81); add(0, 8'h00); add(0, 8'h05); add(0, 8'h01);
                add(0, 8'h00);
                gen_running = 8'hFF;
                add(0, 8'h00); add(0, 8'hFF); add_meta_body(130);
                while (seq_bytes.size() < 290)
                    add_random_event();
                add_delta();
                case (kind % 5)
                    0:
                    begin
                        // program change, then the end marker delta and its zero byte
                        add(0, 8'hC0); add(0, 8'h05);
                        add(0, 8'hFF); add(0, 8'h2F); add(0, 8'h00);
                    end
                    1:
                    begin
                        add(0, 8'hFF); add(0, 8'h2F); add(0, 8'h00);
                    end
                    2:
                    begin
                        add(0, 8'($urandom_range(8'hF0, 8'hFE)));
                        add(0, 8'($urandom_range(0, 255)));
                    end
                    3:
                        add(1, 8'($urandom_range(0, 255)));
                    default:
                    begin
                        add(0, 8'hF3);
                        add(1, 8'h00);
                    end
                endcase
            end
        end
        for (int i = 0; i < 3; i++)
            add($urandom_range(0, 1), 8'($urandom_range(0, 255)));
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                convert_byte(cmd, in_byte);
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (seq_bytes.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
                begin
                    send_gap <= $urandom_range(0, 18);
                    in_valid <= 1'b0;
                end
                else if (seq_bytes.size() > 0)
                begin
                    seq_item_t it;
                    it = seq_bytes.pop_front();
                    in_valid <= 1'b1;
                    cmd <= it.cmd;
                    in_byte <= it.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (midi_expected.size() == 0)
                    report($sformatf("unexpected result byte %h status %0d", out_byte, status));
                else
                begin
                    midi_res_t e;
                    e = midi_expected.pop_front();
                    if (out_byte !== e.midi)
                        report($sformatf("out_byte %h, want %h", out_byte, e.midi));
                    if (status !== e.st)
                        report($sformatf("status %0d, want %0d", status, e.st));
                    if (track_length !== e.tlen)
                        report($sformatf("track_length %0d, want %0d", track_length, e.tlen));
                    if (last !== e.fin)
                        report($sformatf("last %b, want %b", last, e.fin));
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else if (!pressure_done && results_seen >= 60)
            begin
                // long hold so the block backs up into its input
                pressure_done <= 1'b1;
                hold_cycles <= 300;
                out_ready <= 1'b0;
            end
            else if (seq_bytes.size() > QUIET_TAIL && $urandom_range(0, 11) == 0)
            begin
                hold_cycles <= $urandom_range(0, 18);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        ph = PH_SIG;
        hdr_idx = '0;
        tpq = '0;
        tempo = '0;
        ts_num = '0;
        ts_den = '0;
        run_op = '0;
        delta = '0;
        vlq_cnt = '0;
        remaining = '0;
        meta_kind = '0;
        emitted = '0;
        halted = 1'b0;
        build_stream();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (seq_bytes.size() > 0 || in_valid)
            @(posedge clk);
        while (midi_expected.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (midi_expected.size() != 0)
            report("expected results left over");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
